@@ rtl/core/sotbq_pkg.sv @@
package sotbq_pkg;

    typedef enum logic [2:0] {
        CMD_ENQUEUE    = 3'd0,
        CMD_POLL       = 3'd1,
        CMD_FLUSH_PEER = 3'd2,
        CMD_FLUSH_ALL  = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_STATS      = 3'd5
    } t_command;

    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_SEND_NOW = 3'd1;
    localparam logic [2:0] ST_RELEASED = 3'd2;
    localparam logic [2:0] ST_NOTHING  = 3'd3;
    localparam logic [2:0] ST_STATS    = 3'd4;

    localparam logic CFG_BATCH_DELAY = 1'b0;
    localparam logic CFG_BATCH_LIMIT = 1'b1;

    localparam logic [15:0] DELAY_RESET   = 16'd50;
    localparam logic [4:0]  LIMIT_RESET   = 5'd10;
    localparam int          DIV_STEPS     = 32;
    localparam logic [7:0]  SAVINGS_MAX   = 8'd80;
    localparam logic [3:0]  SAVINGS_KNEE  = 4'd9;
    localparam logic [7:0]  SAVINGS_SCALE = 8'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_RD_POLL,
        S_POLL_CHK,
        S_RD,
        S_EMIT,
        S_FIN,
        S_NONE,
        S_DIV,
        S_STATS
    } t_state;

    typedef struct packed {
        logic latch;
        logic tick;
        logic enq_do;
        logic poll_count;
        logic idx_inc;
        logic walk_step;
        logic walk_end;
        logic push_nothing;
        logic div_start;
        logic div_step;
        logic stats_push;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic last_idx;
        logic poll_due;
        logic step_stall;
        logic div_done;
    } t_dp_sts;

endpackage

@@ rtl/core/sotbq_ctrl.sv @@
module sotbq_ctrl
    import sotbq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_command,
    output logic          o_ready,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_command)
                        CMD_ENQUEUE:    n_state = S_ENQ;
                        CMD_POLL:       n_state = i_sts.count_zero ? S_NONE : S_RD_POLL;
                        CMD_FLUSH_PEER: n_state = i_sts.count_zero ? S_NONE : S_RD;
                        CMD_FLUSH_ALL:  n_state = i_sts.count_zero ? S_NONE : S_RD;
                        CMD_TICK:       o_cmd.tick = 1'b1;
                        CMD_STATS: begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_ENQ: begin
                if (i_sts.out_free) begin
                    o_cmd.enq_do = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD_POLL: n_state = S_POLL_CHK;
            S_POLL_CHK: begin
                if (i_sts.poll_due) begin
                    o_cmd.poll_count = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_NONE;
                end
            end
            S_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_sts.step_stall) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.last_idx) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.walk_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push_nothing = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_STATS;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_STATS: begin
                if (i_sts.out_free) begin
                    o_cmd.stats_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/core/sotbq_dp.sv @@
module sotbq_dp
    import sotbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [2:0]          i_command,
    input  logic [31:0]         i_peer_key,
    input  logic [31:0]         i_payload_handle,
    input  logic                i_urgent,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [3:0]          o_slot_index,
    output logic [31:0]         o_out_peer,
    output logic [31:0]         o_out_handle,
    output logic                o_last_of_run,
    output logic [4:0]          o_pending_now,
    output logic [31:0]         o_batch_total,
    output logic signed [7:0]   o_savings_percent
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] peer;
        logic [31:0] handle;
        logic [31:0] stamp;
    } t_entry;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_entry;

    logic [15:0]   r_delay;
    logic [4:0]    r_limit;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_wr;
    logic [31:0]   r_time;
    logic [31:0]   r_enq_total;
    logic [31:0]   r_batches;
    logic [2:0]    r_cmd;
    logic [31:0]   r_key;
    logic [31:0]   r_handle;
    logic          r_urgent;
    logic          r_have;
    logic [31:0]   r_held_peer;
    logic [31:0]   r_held_handle;
    logic [32:0]   r_rem;
    logic [31:0]   r_quo;
    logic [32:0]   r_divisor;
    logic [5:0]    r_div_cnt;

    logic          r_o_valid;
    logic [2:0]    r_o_status;
    logic [3:0]    r_o_slot;
    logic [31:0]   r_o_peer;
    logic [31:0]   r_o_handle;
    logic          r_o_last;
    logic [4:0]    r_o_pending;
    logic [31:0]   r_o_total;
    logic [7:0]    r_o_savings;

    logic          out_free;
    logic          full;
    logic          match;
    logic [31:0]   elapsed;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [33:0]   trial;
    logic          trial_ge;
    logic [7:0]    savings;

    logic          push;
    logic [2:0]    n_status;
    logic [3:0]    n_slot;
    logic [31:0]   n_peer;
    logic [31:0]   n_handle;
    logic          n_last;

    assign out_free = !r_o_valid || i_ready;
    assign full     = ({3'b0, r_count} >= {3'b0, r_limit}) || (r_count >= DEPTH_C);
    assign match    = (r_cmd != CMD_FLUSH_PEER) || (r_rd_entry.peer == r_key);
    assign elapsed  = r_time - r_rd_entry.stamp;
    assign trial    = {r_rem, r_quo[31]};
    assign trial_ge = trial >= {1'b0, r_divisor};

    always_comb begin
        if (r_enq_total == 32'd0) begin
            savings = 8'd0;
        end else if (r_quo >= 32'(SAVINGS_KNEE)) begin
            savings = SAVINGS_MAX;
        end else begin
            savings = 8'({4'b0, r_quo[3:0]} * SAVINGS_SCALE) - SAVINGS_SCALE;
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.last_idx   = ((r_idx + CW'(1)) == r_count);
    assign o_sts.poll_due   = !((elapsed < {16'b0, r_delay}) && !full);
    assign o_sts.step_stall = match && r_have && !out_free;
    assign o_sts.div_done   = (r_div_cnt == 6'(DIV_STEPS));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = r_rd_entry;
        if (i_cmd.enq_do && !(r_urgent || full)) begin
            mem_we    = 1'b1;
            mem_wdata = '{peer: r_key, handle: r_handle, stamp: r_time};
        end else if (i_cmd.walk_step && !match) begin
            mem_we    = 1'b1;
            mem_waddr = r_wr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_entry <= r_mem[r_idx[AW-1:0]];
    end

    // Result selection for the output register.
    always_comb begin
        push     = 1'b0;
        n_status = ST_NOTHING;
        n_slot   = 4'd0;
        n_peer   = 32'd0;
        n_handle = 32'd0;
        n_last   = 1'b1;
        if (i_cmd.enq_do) begin
            push = 1'b1;
            if (r_urgent || full) begin
                n_status = ST_SEND_NOW;
            end else begin
                n_status = ST_QUEUED;
                n_slot   = 4'(r_count);
            end
        end else if (i_cmd.walk_step && match && r_have) begin
            push     = 1'b1;
            n_status = ST_RELEASED;
            n_peer   = r_held_peer;
            n_handle = r_held_handle;
            n_last   = 1'b0;
        end else if (i_cmd.walk_end && r_have) begin
            push     = 1'b1;
            n_status = ST_RELEASED;
            n_peer   = r_held_peer;
            n_handle = r_held_handle;
        end else if (i_cmd.walk_end || i_cmd.push_nothing) begin
            push = 1'b1;
        end else if (i_cmd.stats_push) begin
            push     = 1'b1;
            n_status = ST_STATS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_o_status  <= n_status;
            r_o_slot    <= n_slot;
            r_o_peer    <= n_peer;
            r_o_handle  <= n_handle;
            r_o_last    <= n_last;
            r_o_pending <= i_cmd.stats_push ? 5'(r_count) : 5'd0;
            r_o_total   <= i_cmd.stats_push ? r_batches : 32'd0;
            r_o_savings <= i_cmd.stats_push ? savings : 8'd0;
        end
        if (i_cmd.latch) begin
            r_cmd    <= i_command;
            r_key    <= i_peer_key;
            r_handle <= i_payload_handle;
            r_urgent <= i_urgent;
        end
        if (i_cmd.walk_step && match) begin
            r_held_peer   <= r_rd_entry.peer;
            r_held_handle <= r_rd_entry.handle;
        end
        if (i_cmd.div_start) begin
            r_rem     <= 33'd0;
            r_quo     <= r_enq_total;
            r_divisor <= {1'b0, r_batches} + 33'd1;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 33'(trial - {1'b0, r_divisor}) : trial[32:0];
            r_quo <= {r_quo[30:0], trial_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid   <= 1'b0;
            r_delay     <= DELAY_RESET;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_time      <= 32'd0;
            r_enq_total <= 32'd0;
            r_batches   <= 32'd0;
            r_have      <= 1'b0;
            r_div_cnt   <= 6'd0;
        end else begin
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BATCH_DELAY) begin
                    r_delay <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data[4:0];
                end
            end
            if (i_cmd.latch) begin
                r_idx  <= '0;
                r_wr   <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.tick) begin
                r_time <= r_time + 32'd1;
            end
            if (i_cmd.enq_do && !(r_urgent || full)) begin
                r_count     <= r_count + CW'(1);
                r_enq_total <= r_enq_total + 32'd1;
            end
            if (i_cmd.poll_count) begin
                r_batches <= r_batches + 32'd1;
            end
            if (i_cmd.walk_step) begin
                if (match) begin
                    r_have <= 1'b1;
                end else begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (i_cmd.walk_end) begin
                r_count <= r_wr;
                r_have  <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= 6'd0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 6'd1;
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_slot_index      = r_o_slot;
    assign o_out_peer        = r_o_peer;
    assign o_out_handle      = r_o_handle;
    assign o_last_of_run     = r_o_last;
    assign o_pending_now     = r_o_pending;
    assign o_batch_total     = r_o_total;
    assign o_savings_percent = $signed(r_o_savings);

endmodule

@@ rtl/core/size_or_timeout_batch_queue_top.sv @@
// Batching queue for outgoing message handles, released by size or by age.
// Commands enter on the input channel (i_valid / o_ready); each transaction
// carries a command, a peer key, a payload handle and an urgent flag.
// Results leave on the output channel (o_valid / i_ready), one transaction
// per result, with o_last_of_run marking the final result of a command.
// Configuration writes (batch delay, batch limit) use their own, always
// ready channel. The user must make them while the queue is idle; the
// block does not enforce it. One command is worked on at a time. Tick
// finishes in the idle state; enqueue waits in its own state for a free
// output register. Poll and the flushes walk the stored entries through
// a single-port read of the entry memory, a read state and then an emit
// state per entry. Stats runs a bit-serial divider of 32 steps.
// Reset clears the pending count, the time, both counters and the output
// valid; entry storage is not cleared since only written slots are read.
// When the receiver stalls, the finished result waits in the output
// register and the command sequencer pauses until that register frees.
module size_or_timeout_batch_queue_top
    import sotbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_command,
    input  logic [31:0]       i_peer_key,
    input  logic [31:0]       i_payload_handle,
    input  logic              i_urgent,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [3:0]        o_slot_index,
    output logic [31:0]       o_out_peer,
    output logic [31:0]       o_out_handle,
    output logic              o_last_of_run,
    output logic [4:0]        o_pending_now,
    output logic [31:0]       o_batch_total,
    output logic signed [7:0] o_savings_percent
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Register writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    sotbq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    sotbq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_command         (i_command),
        .i_peer_key        (i_peer_key),
        .i_payload_handle  (i_payload_handle),
        .i_urgent          (i_urgent),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slot_index      (o_slot_index),
        .o_out_peer        (o_out_peer),
        .o_out_handle      (o_out_handle),
        .o_last_of_run     (o_last_of_run),
        .o_pending_now     (o_pending_now),
        .o_batch_total     (o_batch_total),
        .o_savings_percent (o_savings_percent)
    );

endmodule

@@ verif/size_or_timeout_batch_queue_top_test.sv @@
`timescale 1ns / 1ps

// Testbench for the size-or-timeout batching queue.
// Commands go in on the input channel. For each accepted transaction, a model
// kept here works out which result transactions must follow, and those are
// pushed onto a list of awaited results. A monitor takes each accepted result
// transaction off the front of that list and compares every field.
// Both channels idle at random. One test holds the result channel off for a
// long time so that the output register fills and the input channel stalls.
module size_or_timeout_batch_queue_top_test;
    import sotbq_pkg::*;

    // Command codes that the block must ignore without a result.
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
    localparam int DEPTH = 16;
    localparam int LONG_HOLD_CYCLES = 160;
    // Tick and ignored commands give no result, so the block may still be busy
    // when the list of awaited results runs empty.
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        slot;
        logic [31:0]       peer;
        logic [31:0]       handle;
        logic              last;
        logic [4:0]        pend;
        logic [31:0]       total;
        logic signed [7:0] savings;
    } t_batch_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [2:0]        i_command = CMD_TICK;
    logic [31:0]       i_peer_key = '0;
    logic [31:0]       i_payload_handle = '0;
    logic              i_urgent = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = CFG_BATCH_DELAY;
    logic [15:0]       i_cfg_data = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [2:0]        o_status;
    logic [3:0]        o_slot_index;
    logic [31:0]       o_out_peer;
    logic [31:0]       o_out_handle;
    logic              o_last_of_run;
    logic [4:0]        o_pending_now;
    logic [31:0]       o_batch_total;
    logic signed [7:0] o_savings_percent;

    size_or_timeout_batch_queue_top u_top (.*);

    always #10 i_clk = ~i_clk;

    // Model of the queue: its stored entries, counters, time and registers.
    logic [31:0] q_peer [DEPTH];
    logic [31:0] q_handle [DEPTH];
    logic [31:0] q_stamp [DEPTH];
    int unsigned q_pending;
    logic [31:0] q_time;
    logic [31:0] q_enqueued;
    logic [31:0] q_batches;
    logic [15:0] q_delay;
    logic [4:0]  q_limit;

    t_batch_result awaited_results[$];

    // Controls of the random idling on both channels and of the long hold-off.
    bit idle_enable = 1'b1;
    bit long_hold_request = 1'b0;
    int mismatch_count = 0;
    int commands_sent = 0;
    int results_seen = 0;
    int config_writes = 0;
    int hold_count = 0;

    function automatic int unsigned effective_limit();
        return (q_limit < DEPTH) ? q_limit : DEPTH;
    endfunction

    function automatic void push_result(logic [2:0] status, logic [3:0] slot,
                                        logic [31:0] peer, logic [31:0] handle,
                                        logic [4:0] pend, logic [31:0] total,
                                        logic signed [7:0] savings);
        t_batch_result r;
        r = '{status, slot, peer, handle, 1'b0, pend, total, savings};
        awaited_results = {awaited_results, r};
    endfunction

    // Every command that gives results gives at least one; the final one is
    // flagged as the last of the run.
    function automatic void close_run(int produced);
        if (produced == 0)
            push_result(ST_NOTHING, '0, '0, '0, '0, '0, '0);
        awaited_results[awaited_results.size() - 1].last = 1'b1;
    endfunction

    function automatic int release_everything();
        int n;
        n = 0;
        for (int i = 0; i < q_pending; i++) begin
            push_result(ST_RELEASED, '0, q_peer[i], q_handle[i], '0, '0, '0);
            n++;
        end
        q_pending = 0;
        return n;
    endfunction

    function automatic void predict_batch_queue(logic [2:0] cmd, logic [31:0] peer,
                                                logic [31:0] handle, logic urg);
        int n;
        int unsigned w;
        logic [31:0] elapsed;
        longint avg;
        longint est;
        n = 0;
        case (cmd)
            CMD_ENQUEUE: begin
                if (urg || q_pending >= effective_limit()) begin
                    push_result(ST_SEND_NOW, '0, '0, '0, '0, '0, '0);
                end else begin
                    w = q_pending;
                    q_peer[w] = peer;
                    q_handle[w] = handle;
                    q_stamp[w] = q_time;
                    q_pending = w + 1;
                    q_enqueued = q_enqueued + 1;
                    push_result(ST_QUEUED, w[3:0], '0, '0, '0, '0, '0);
                end
                close_run(1);
            end
            CMD_POLL: begin
                if (q_pending != 0) begin
                    elapsed = q_time - q_stamp[0];
                    // Released when old enough or when the batch is full.
                    if (!(elapsed < q_delay && q_pending < effective_limit())) begin
                        n = release_everything();
                        q_batches = q_batches + 1;
                    end
                end
                close_run(n);
            end
            CMD_FLUSH_PEER: begin
                w = 0;
                for (int i = 0; i < q_pending; i++) begin
                    if (q_peer[i] == peer) begin
                        push_result(ST_RELEASED, '0, q_peer[i], q_handle[i], '0, '0, '0);
                        n++;
                    end else begin
                        q_peer[w] = q_peer[i];
                        q_handle[w] = q_handle[i];
                        q_stamp[w] = q_stamp[i];
                        w++;
                    end
                end
                q_pending = w;
                close_run(n);
            end
            CMD_FLUSH_ALL: begin
                n = release_everything();
                close_run(n);
            end
            CMD_TICK: q_time = q_time + 1;
            CMD_STATS: begin
                est = 0;
                if (q_enqueued != 0) begin
                    avg = longint'(q_enqueued) / (longint'(q_batches) + 1);
                    est = (avg - 1) * 10;
                    if (est > 80)
                        est = 80;
                end
                push_result(ST_STATS, '0, '0, '0, q_pending[4:0], q_batches, est[7:0]);
                close_run(1);
            end
            default: ;
        endcase
    endfunction

    // Offers one command and returns at the edge where it is accepted, with
    // valid still high so that the next command can follow without a gap.
    // Handshakes are sampled at the falling edge, where all signals are stable.
    task automatic send_command(logic [2:0] cmd, logic [31:0] peer,
                                logic [31:0] handle, logic urg);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_peer_key <= peer;
        i_payload_handle <= handle;
        i_urgent <= urg;
        @(negedge i_clk);
        while (!o_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        predict_batch_queue(cmd, peer, handle, urg);
        commands_sent++;
    endtask

    // Lowers valid and waits until every awaited result has arrived and the
    // block has had time to finish any command that gives no result.
    task automatic drain_queue();
        i_valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [15:0] value);
        drain_queue();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == CFG_BATCH_DELAY)
            q_delay = value;
        else
            q_limit = value[4:0];
        config_writes++;
        @(posedge i_clk);
    endtask

    // A peer from a small set most of the time so that peer flushes find
    // matches, otherwise any 32-bit value.
    function automatic logic [31:0] pick_peer();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1234_5678;
            3: return 32'hA5A5_0001;
            default: return $urandom;
        endcase
    endfunction

    // Result channel: random stalls, and a long counted hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_request) begin
                i_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                long_hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result monitor. A transaction seen at the falling edge completes at the
    // next rising edge, since both sides only change right after rising edges.
    always @(negedge i_clk) begin
        t_batch_result got;
        t_batch_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            got = '{o_status, o_slot_index, o_out_peer, o_out_handle, o_last_of_run,
                    o_pending_now, o_batch_total, o_savings_percent};
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result status=%0d peer=%h handle=%h",
                             got.status, got.peer, got.handle);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result %0d mismatch", results_seen);
                        $write("  expected st=%0d slot=%0d peer=%h hdl=%h last=%b",
                               want.status, want.slot, want.peer, want.handle, want.last);
                        $display(" pend=%0d tot=%0d sav=%0d",
                                 want.pend, want.total, want.savings);
                        $write("  actual   st=%0d slot=%0d peer=%h hdl=%h last=%b",
                               got.status, got.slot, got.peer, got.handle, got.last);
                        $display(" pend=%0d tot=%0d sav=%0d",
                                 got.pend, got.total, got.savings);
                    end
                end
            end
        end
    end

    // Empty queue, ignored commands, urgent bypass, field extremes, peer
    // flush with compaction, a poll that is not yet due, and stats, all at
    // the reset register values.
    task automatic test_basic_commands();
        send_command(CMD_STATS, '0, '0, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_FLUSH_PEER, 32'hFFFF_FFFF, '0, 1'b0);
        send_command(CMD_FLUSH_ALL, '0, '0, 1'b0);
        send_command(CMD_TICK, '0, '0, 1'b0);
        send_command(CMD_UNUSED_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_UNUSED_7, '0, '0, 1'b0);
        send_command(CMD_ENQUEUE, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1);
        send_command(CMD_ENQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_command(CMD_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_command(CMD_ENQUEUE, 32'h0000_0000, 32'h5555_AAAA, 1'b0);
        send_command(CMD_ENQUEUE, 32'h1234_5678, 32'hAAAA_5555, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_FLUSH_PEER, 32'h0000_0000, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
        send_command(CMD_FLUSH_PEER, 32'h9999_9999, '0, 1'b0);
        send_command(CMD_FLUSH_ALL, '0, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
    endtask

    // Register extremes: a zero limit (always full), a limit of one, a limit
    // above the queue depth, the longest delay and no delay at all.
    task automatic test_register_extremes();
        write_register(CFG_BATCH_LIMIT, 16'd0);
        send_command(CMD_ENQUEUE, 32'h0000_0001, 32'h0000_0001, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        write_register(CFG_BATCH_LIMIT, 16'd1);
        write_register(CFG_BATCH_DELAY, 16'hFFFF);
        send_command(CMD_ENQUEUE, 32'h0000_0002, 32'h0000_0002, 1'b0);
        send_command(CMD_ENQUEUE, 32'h0000_0003, 32'h0000_0003, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
        write_register(CFG_BATCH_LIMIT, 16'd31);
        for (int i = 0; i < DEPTH + 1; i++)
            send_command(CMD_ENQUEUE, pick_peer(), $urandom, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
        write_register(CFG_BATCH_DELAY, 16'd0);
        write_register(CFG_BATCH_LIMIT, 16'd16);
        send_command(CMD_ENQUEUE, 32'h0000_0004, 32'h0000_0004, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
        // A stored entry stays pending while the limit drops to zero; the
        // next poll then counts the batch as full.
        write_register(CFG_BATCH_DELAY, 16'd3);
        send_command(CMD_ENQUEUE, 32'h0000_0005, 32'h0000_0005, 1'b0);
        write_register(CFG_BATCH_LIMIT, 16'd0);
        send_command(CMD_POLL, '0, '0, 1'b0);
    endtask

    // Fill the queue, then hold the result channel off while a full flush and
    // further commands are offered, so the output stalls back into the input.
    task automatic test_output_backpressure();
        write_register(CFG_BATCH_LIMIT, 16'd16);
        write_register(CFG_BATCH_DELAY, 16'd2);
        for (int i = 0; i < DEPTH; i++)
            send_command(CMD_ENQUEUE, pick_peer(), $urandom, 1'b0);
        long_hold_request = 1'b1;
        send_command(CMD_FLUSH_ALL, '0, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
        send_command(CMD_ENQUEUE, 32'h0BAD_F00D, 32'h1111_2222, 1'b0);
        send_command(CMD_ENQUEUE, 32'h0BAD_F00D, 32'h3333_4444, 1'b0);
        send_command(CMD_POLL, '0, '0, 1'b0);
        send_command(CMD_FLUSH_PEER, 32'h0BAD_F00D, '0, 1'b0);
        send_command(CMD_STATS, '0, '0, 1'b0);
    endtask

    task automatic test_random_traffic(int count, logic [15:0] delay, logic [4:0] limit);
        int unsigned pick;
        write_register(CFG_BATCH_DELAY, delay);
        write_register(CFG_BATCH_LIMIT, {11'd0, limit});
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_command(CMD_ENQUEUE, pick_peer(), $urandom, $urandom_range(0, 9) == 0);
            else if (pick < 62)
                send_command(CMD_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 77)
                send_command(CMD_POLL, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 85)
                send_command(CMD_FLUSH_PEER, pick_peer(), $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 90)
                send_command(CMD_FLUSH_ALL, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 96)
                send_command(CMD_STATS, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else
                send_command(pick[0] ? CMD_UNUSED_7 : CMD_UNUSED_6, $urandom, $urandom, 1'b1);
        end
    endtask

    initial begin
        int wait_cycles;
        for (int i = 0; i < DEPTH; i++) begin
            q_peer[i] = '0;
            q_handle[i] = '0;
            q_stamp[i] = '0;
        end
        q_pending = 0;
        q_time = '0;
        q_enqueued = '0;
        q_batches = '0;
        q_delay = DELAY_RESET;
        q_limit = LIMIT_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_commands();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(30, 16'($urandom_range(0, 4)), 5'($urandom_range(1, 4)));
        test_random_traffic(30, 16'($urandom_range(2, 8)), 5'($urandom_range(5, 16)));
        test_random_traffic(20, 16'($urandom_range(0, 3)), 5'($urandom_range(1, 16)));
        // The closing stretch runs with no random idling on either channel.
        idle_enable = 1'b0;
        test_random_traffic(20, 16'd1, 5'd6);

        i_valid <= 1'b0;
        wait_cycles = 0;
        while (awaited_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d results over %0d register writes,",
                 commands_sent, results_seen, config_writes);
        $display("including a held-off result channel and limits from zero to above depth.");
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("size_or_timeout_batch_queue_top test passed");
        end else begin
            $display("size_or_timeout_batch_queue_top test failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #10ms;
        $display("ERROR: timeout");
        $display("size_or_timeout_batch_queue_top test failed");
        $finish;
    end

endmodule
